// ----- sv/euler_rotation_3d_unit_defines.svh -----
// assertion macros for the euler rotation unit
`ifndef EULER_ROTATION_3D_UNIT_DEFINES_SVH
`define EULER_ROTATION_3D_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ERU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ERU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/eulrot_pkg.sv -----
// types, constants and helper functions of the euler rotation unit
`timescale 1ns / 1ps

package eulrot_pkg;

  localparam int VEC_W      = 32;
  localparam int COEF_FRAC  = 30;
  localparam int COEF_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int MAT_W      = COEF_W + 1;
  localparam int PROD_W     = MAT_W + VEC_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CPROD_W    = 2 * COEF_W;
  localparam int TDATA_W    = ((3 * VEC_W + 7) / 8) * 8;
  localparam int NUM_STAGES = 5;

  localparam logic [CFG_IDX_W-1:0] REG_COS_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_THIRD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_THIRD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_CONV  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BACKWARD   = 3'd7;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [CPROD_W-1:0] cprod_t;

  localparam coef_t  COEF_ONE   = coef_t'(1) <<< COEF_FRAC;
  localparam coef_t  COEF_M_ONE = -COEF_ONE;
  localparam cprod_t CPROD_HALF = cprod_t'(1) <<< (COEF_FRAC - 1);
  localparam sum_t   SUM_HALF   = sum_t'(1) <<< (COEF_FRAC - 1);
  localparam sum_t   VEC_MAX    = {{(SUM_W - VEC_W + 1){1'b0}}, {(VEC_W - 1){1'b1}}};
  localparam sum_t   VEC_MIN    = ~VEC_MAX;

  typedef struct packed {
    vec_t [2:0] v;
    coef_t      c2;
    coef_t      c3;
    coef_t      s3;
    coef_t      t;
    coef_t      u;
    coef_t      c1c3;
    coef_t      c1s3;
    coef_t      s1s2;
    coef_t      s1c3;
    coef_t      c1s2;
    coef_t      s1s3;
    coef_t      s2s3;
    coef_t      s2c3;
    logic       bwd;
  } st1_t;

  typedef struct packed {
    vec_t [2:0] v;
    coef_t      c2;
    coef_t      c1c3;
    coef_t      c1s3;
    coef_t      s1s2;
    coef_t      s1c3;
    coef_t      c1s2;
    coef_t      s1s3;
    coef_t      s2s3;
    coef_t      s2c3;
    coef_t      ts3;
    coef_t      tc3;
    coef_t      us3;
    coef_t      uc3;
    logic       bwd;
  } st2_t;

  typedef struct packed {
    vec_t [2:0] v;
    mat_t [8:0] m;
  } st3_t;

  // product of two coefficients, rounded half up to the coefficient scale
  function automatic coef_t rnd_mul(coef_t a, coef_t b);
    cprod_t p;
    p = cprod_t'(a) * cprod_t'(b) + CPROD_HALF;
    return p[COEF_FRAC +: COEF_W];
  endfunction

  // clamp a written word to the coefficient range
  function automatic coef_t clamp_coef(logic [CFG_W-1:0] w, logic unsigned_reg);
    coef_t x;
    x = unsigned_reg ? coef_t'({1'b0, w[CFG_W-2:0]}) : coef_t'(signed'(w));
    if (x > COEF_ONE) begin
      return COEF_ONE;
    end else if (x < COEF_M_ONE) begin
      return COEF_M_ONE;
    end
    return x;
  endfunction

  // round half up, drop the coefficient fraction and saturate to the vector range
  function automatic vec_t round_sat(sum_t s);
    sum_t r;
    r = (s + SUM_HALF) >>> COEF_FRAC;
    if (r > VEC_MAX) begin
      return VEC_MAX[VEC_W-1:0];
    end else if (r < VEC_MIN) begin
      return VEC_MIN[VEC_W-1:0];
    end
    return r[VEC_W-1:0];
  endfunction

endpackage

// ----- sv/euler_rotation_3d_unit.sv -----
// euler angle rotation of 3-d vectors, five-stage pipeline
`timescale 1ns / 1ps
//
// channel   | direction | contents
// in_       | slave     | tdata: x_in, y_in, z_in (signed)
// out_      | master    | tdata: x_out, y_out, z_out (signed, saturated)
// cfg_      | write     | cfg_addr selects one of eight registers
//
// one item per cycle unless out_tready is low with the pipe full; five register stages
// (first-level matrix products, second-level products, matrix sum and transpose,
// matrix-vector products, final sum with rounding and saturation)
// synchronous reset loads identity angles with backward mode and empties the pipe
// a stage takes a new item whenever it is empty or its successor moves on,
// so bubbles close up and out_tready low stalls only the stages behind a full one

`include "euler_rotation_3d_unit_defines.svh"

module euler_rotation_3d_unit
  import eulrot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // x_in, y_in, z_in
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // x_out, y_out, z_out
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  coef_t cos1_r, sin1_r, cos2_r, sin2_r, cos3_r, sin3_r;
  logic  zyz_r, bwd_r;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] rdy;

  st1_t       s1_r, s1_nxt;
  st2_t       s2_r, s2_nxt;
  st3_t       s3_r, s3_nxt;
  prod_t [8:0] s4_r, s4_nxt;
  vec_t  [2:0] s5_r, s5_nxt;

  coef_t c1, s1, c3, s3;
  mat_t  [8:0] rm;

  logic in_acc, out_acc;

  // configuration registers, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos1_r <= COEF_ONE;
      sin1_r <= '0;
      cos2_r <= COEF_ONE;
      sin2_r <= '0;
      cos3_r <= COEF_ONE;
      sin3_r <= '0;
      zyz_r  <= 1'b0;
      bwd_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COS_FIRST:  cos1_r <= clamp_coef(cfg_wdata, 1'b0);
        REG_SIN_FIRST:  sin1_r <= clamp_coef(cfg_wdata, 1'b0);
        REG_COS_SECOND: cos2_r <= clamp_coef(cfg_wdata, 1'b0);
        REG_SIN_SECOND: sin2_r <= clamp_coef(cfg_wdata, 1'b1);
        REG_COS_THIRD:  cos3_r <= clamp_coef(cfg_wdata, 1'b0);
        REG_SIN_THIRD:  sin3_r <= clamp_coef(cfg_wdata, 1'b0);
        REG_AXIS_CONV:  zyz_r  <= cfg_wdata[0];
        REG_BACKWARD:   bwd_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ready chain: a stage loads when empty or when its successor moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[0];
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_acc    = out_tvalid && out_tready;

  // stage 1: zyz remap and first-level products
  always_comb begin
    c1 = zyz_r ? -sin1_r : cos1_r;
    s1 = zyz_r ? cos1_r  : sin1_r;
    c3 = zyz_r ? sin3_r  : cos3_r;
    s3 = zyz_r ? -cos3_r : sin3_r;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.v[i] = in_tdata[i*VEC_W +: VEC_W];
    end
    s1_nxt.c2   = cos2_r;
    s1_nxt.c3   = c3;
    s1_nxt.s3   = s3;
    s1_nxt.t    = rnd_mul(s1, cos2_r);
    s1_nxt.u    = rnd_mul(c1, cos2_r);
    s1_nxt.c1c3 = rnd_mul(c1, c3);
    s1_nxt.c1s3 = rnd_mul(c1, s3);
    s1_nxt.s1s2 = rnd_mul(s1, sin2_r);
    s1_nxt.s1c3 = rnd_mul(s1, c3);
    s1_nxt.c1s2 = rnd_mul(c1, sin2_r);
    s1_nxt.s1s3 = rnd_mul(s1, s3);
    s1_nxt.s2s3 = rnd_mul(sin2_r, s3);
    s1_nxt.s2c3 = rnd_mul(sin2_r, c3);
    s1_nxt.bwd  = bwd_r;
  end

  // stage 2: second-level products
  always_comb begin
    s2_nxt.v    = s1_r.v;
    s2_nxt.c2   = s1_r.c2;
    s2_nxt.c1c3 = s1_r.c1c3;
    s2_nxt.c1s3 = s1_r.c1s3;
    s2_nxt.s1s2 = s1_r.s1s2;
    s2_nxt.s1c3 = s1_r.s1c3;
    s2_nxt.c1s2 = s1_r.c1s2;
    s2_nxt.s1s3 = s1_r.s1s3;
    s2_nxt.s2s3 = s1_r.s2s3;
    s2_nxt.s2c3 = s1_r.s2c3;
    s2_nxt.ts3  = rnd_mul(s1_r.t, s1_r.s3);
    s2_nxt.tc3  = rnd_mul(s1_r.t, s1_r.c3);
    s2_nxt.us3  = rnd_mul(s1_r.u, s1_r.s3);
    s2_nxt.uc3  = rnd_mul(s1_r.u, s1_r.c3);
    s2_nxt.bwd  = s1_r.bwd;
  end

  // stage 3: matrix entries, transposed in backward mode
  always_comb begin
    rm[0] = mat_t'(s2_r.c1c3) - mat_t'(s2_r.ts3);
    rm[1] = -mat_t'(s2_r.c1s3) - mat_t'(s2_r.tc3);
    rm[2] = mat_t'(s2_r.s1s2);
    rm[3] = mat_t'(s2_r.s1c3) + mat_t'(s2_r.us3);
    rm[4] = mat_t'(s2_r.uc3) - mat_t'(s2_r.s1s3);
    rm[5] = -mat_t'(s2_r.c1s2);
    rm[6] = mat_t'(s2_r.s2s3);
    rm[7] = mat_t'(s2_r.s2c3);
    rm[8] = mat_t'(s2_r.c2);
    s3_nxt.v = s2_r.v;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_nxt.m[3*i+j] = s2_r.bwd ? rm[3*j+i] : rm[3*i+j];
      end
    end
  end

  // stage 4: matrix-vector products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s4_nxt[3*i+j] = prod_t'(signed'(s3_r.m[3*i+j])) * prod_t'(signed'(s3_r.v[j]));
      end
    end
  end

  // stage 5: row sums, rounding and saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_nxt[i] = round_sat(sum_t'(signed'(s4_r[3*i])) + sum_t'(signed'(s4_r[3*i+1]))
                            + sum_t'(signed'(s4_r[3*i+2])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r <= s1_nxt;
    end
    if (rdy[1]) begin
      s2_r <= s2_nxt;
    end
    if (rdy[2]) begin
      s3_r <= s3_nxt;
    end
    if (rdy[3]) begin
      s4_r <= s4_nxt;
    end
    if (rdy[4]) begin
      s5_r <= s5_nxt;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      out_tdata[i*VEC_W +: VEC_W] = s5_r[i];
    end
  end

  `ERU_ASSERT_NEXT(a_accept_fills_first, in_acc, vld_r[0], "accepted item missing in first stage")
  `ERU_ASSERT_NEXT(a_count_hold, !in_acc && !out_acc,
                   $countones(vld_r) == $past($countones(vld_r)), "item count changed while idle")
  `ERU_ASSERT_NEXT(a_count_grow, in_acc && !out_acc,
                   $countones(vld_r) == $past($countones(vld_r)) + 1, "accepted item lost")

endmodule
